[hw/rtl/chord_keyboard_decoder_assert.svh]
// Assertion macros for the chord keyboard decoder.
// Included by the modules that check their own logic; needs no package.
`ifndef CHORD_KEYBOARD_DECODER_ASSERT_SVH
`define CHORD_KEYBOARD_DECODER_ASSERT_SVH

// Generic form with an explicit clock and synchronous reset.
`define CKD_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Form for modules clocked by clock and reset by reset.
`define CKD_ASSERT(label, prop, msg) `CKD_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

[hw/rtl/ckd_pkg.sv]
// Package for the chord keyboard decoder: payload widths, state layout,
// modifier and shift codes, and the fixed code tables. No dependencies.
package ckd_pkg;

   localparam int KeysWidth = 8;
   localparam int CodeWidth = 8;

   typedef logic [KeysWidth-1:0] keys_type;
   typedef logic [CodeWidth-1:0] code_type;

   // Modifier nibble codes (upper four bits of a chord).
   localparam logic [3:0] ModNone     = 4'h0;
   localparam logic [3:0] ModThumb    = 4'h1;
   localparam logic [3:0] ModCaps     = 4'h2;
   localparam logic [3:0] ModNum      = 4'h4;
   localparam logic [3:0] ModThumbCaps = 4'h3;
   localparam logic [3:0] ModThumbNum = 4'h5;
   localparam logic [3:0] ModNumCaps  = 4'h6;

   // Shift state codes.
   localparam logic [1:0] ShiftOff       = 2'd0;
   localparam logic [1:0] ShiftTransient = 2'd1;
   localparam logic [1:0] ShiftLocked    = 2'd2;

   typedef struct packed {
      logic       eshift_pending;
      logic [1:0] num_state;
      logic [1:0] caps_state;
      keys_type   chord_accum;
   } state_type;

   typedef code_type table_type [16];

   localparam table_type BasicTable = '{
      8'h00, 8'h75, 8'h73, 8'h67, 8'h6F, 8'h71, 8'h6E, 8'h62,
      8'h65, 8'h76, 8'h74, 8'h2C, 8'h61, 8'h0A, 8'h2E, 8'h6D};
   localparam table_type ThumbTable = '{
      8'h20, 8'h68, 8'h6B, 8'h6A, 8'h63, 8'h7A, 8'h79, 8'h78,
      8'h69, 8'h6C, 8'h72, 8'h77, 8'h64, 8'h27, 8'h66, 8'h70};
   localparam table_type NumberTable = '{
      8'h31, 8'h36, 8'h24, 8'h37, 8'h30, 8'h07, 8'h23, 8'h38,
      8'h32, 8'hA3, 8'h2B, 8'h39, 8'h33, 8'h2D, 8'h34, 8'h35};
   localparam table_type NumShiftTable = '{
      8'h00, 8'h5F, 8'h5B, 8'h3E, 8'h28, 8'h2F, 8'h2D, 8'h7B,
      8'h3D, 8'h21, 8'h09, 8'h2C, 8'h2B, 8'h0A, 8'h2E, 8'h2A};
   localparam table_type EShiftTable = '{
      8'h00, 8'h5E, 8'h5D, 8'h3C, 8'h29, 8'h5C, 8'h7E, 8'h7D,
      8'h15, 8'h7C, 8'h16, 8'h3B, 8'h40, 8'h0A, 8'h3A, 8'h17};
   localparam table_type EThumbTable = '{
      8'h0B, 8'h10, 8'h26, 8'h11, 8'h14, 8'h25, 8'h3F, 8'h12,
      8'h0C, 8'h80, 8'h2D, 8'h13, 8'h0D, 8'h22, 8'h0E, 8'h0F};
   localparam table_type CommandTable = '{
      8'h00, 8'h18, 8'h19, 8'h1A, 8'h07, 8'h1B, 8'h1C, 8'h1D,
      8'h1E, 8'h1F, 8'h09, 8'h01, 8'h1E, 8'h02, 8'h03, 8'h04};
   localparam table_type CounterTable = '{
      8'h00, 8'h00, 8'h00, 8'h18, 8'h00, 8'h02, 8'h04, 8'h82,
      8'h05, 8'h06, 8'h00, 8'h81, 8'h01, 8'h00, 8'h19, 8'h00};

   function automatic code_type upper_az(code_type c);
      code_type r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   function automatic logic [1:0] step_lock(logic [1:0] s);
      logic [1:0] r;
      r = (s >= ShiftLocked) ? ShiftOff : s + 2'd1;
      return r;
   endfunction

endpackage

[hw/rtl/ckd_req_if.sv]
// Input channel of the chord keyboard decoder: one switch scan per beat.
// Depends on ckd_pkg.
interface ckd_req_if;
   logic              valid;
   logic              ready;
   ckd_pkg::keys_type pressed_keys;

   modport source (output valid, output pressed_keys, input ready);
   modport sink   (input valid, input pressed_keys, output ready);
endinterface

[hw/rtl/ckd_rsp_if.sv]
// Result channel of the chord keyboard decoder: one decoded code per beat.
// Depends on ckd_pkg.
interface ckd_rsp_if;
   logic              valid;
   logic              ready;
   ckd_pkg::code_type key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);
endinterface

[hw/rtl/chord_keyboard_decoder.sv]
// Chord keyboard decoder top level.
// Depends on ckd_pkg, ckd_req_if, ckd_rsp_if and chord_keyboard_decoder_assert.svh.
//
// Usage: each req beat carries one scan of the eight switches (bits 0..3
// fingers, 4 thumb, 5 caps, 6 num, 7 repeat). Nonzero scans are ORed into a
// chord. The first all-released scan after a nonempty chord decodes it; a
// nonzero code leaves on rsp as one beat, others only update shift states.
// Path: the releasing beat is registered into the decode stage when accepted,
// decoded there, and its code is registered in the rsp output register.
// Throughput: one req beat per cycle while rsp does not stall, with a
// read-modify-write of the state memory per beat (read registered,
// last write forwarded to the next beat).
// Reset: reset is synchronous; while it is held the one-entry state memory
// is written to zero, so all shift states are off and the chord is empty
// afterwards.
// Stall: a result waits in the rsp output register. While it is held, the
// beat in the decode stage waits too and req.ready drops; a scan already
// accepted is never lost.
module chord_keyboard_decoder (
   input  logic      clock,
   input  logic      reset,
   ckd_req_if.sink   req,
   ckd_rsp_if.source rsp
);

   `include "chord_keyboard_decoder_assert.svh"

   ckd_pkg::state_type state_mem [1];
   ckd_pkg::state_type rd_state_ff;
   ckd_pkg::state_type fwd_state_ff;
   logic               fwd_valid_ff;

   logic               s1_valid_ff;
   ckd_pkg::keys_type  s1_keys_ff;
   logic               rsp_valid_ff;
   ckd_pkg::code_type  rsp_code_ff;

   ckd_pkg::state_type cur_state;
   ckd_pkg::state_type state_in;
   ckd_pkg::code_type  code;
   logic [3:0]         mods;
   logic [3:0]         fingers;
   logic               out_free;
   logic               s1_adv;
   logic               req_take;
   logic               produce;
   logic               thumb_sel;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || s1_adv;
   assign req_take  = req.valid && req.ready;

   assign cur_state = fwd_valid_ff ? fwd_state_ff : rd_state_ff;
   assign mods      = cur_state.chord_accum[7:4];
   assign fingers   = cur_state.chord_accum[3:0];
   assign thumb_sel = (mods == ckd_pkg::ModThumb);

   always_comb begin
      state_in = cur_state;
      code     = '0;
      if (s1_keys_ff != '0) begin
         state_in.chord_accum = cur_state.chord_accum | s1_keys_ff;
      end else if (cur_state.chord_accum != '0) begin
         state_in.chord_accum = '0;
         priority if (mods == ckd_pkg::ModNone || mods == ckd_pkg::ModThumb) begin
            priority if (cur_state.eshift_pending) begin
               code = thumb_sel ? ckd_pkg::EThumbTable[fingers]
                                : ckd_pkg::EShiftTable[fingers];
               state_in.eshift_pending = 1'b0;
            end else if (cur_state.num_state != ckd_pkg::ShiftOff) begin
               code = thumb_sel ? ckd_pkg::NumberTable[fingers]
                                : ckd_pkg::NumShiftTable[fingers];
               if (cur_state.num_state == ckd_pkg::ShiftTransient) begin
                  state_in.num_state = ckd_pkg::ShiftOff;
               end
            end else if (cur_state.caps_state != ckd_pkg::ShiftOff) begin
               code = ckd_pkg::upper_az(thumb_sel ? ckd_pkg::ThumbTable[fingers]
                                                  : ckd_pkg::BasicTable[fingers]);
               if (cur_state.caps_state == ckd_pkg::ShiftTransient) begin
                  state_in.caps_state = ckd_pkg::ShiftOff;
               end
            end else begin
               code = thumb_sel ? ckd_pkg::ThumbTable[fingers]
                                : ckd_pkg::BasicTable[fingers];
            end
         end else if (mods == ckd_pkg::ModNum) begin
            if (cur_state.eshift_pending) begin
               code = ckd_pkg::CounterTable[fingers];
               state_in.eshift_pending = 1'b0;
            end else begin
               code = ckd_pkg::NumberTable[fingers];
            end
         end else if (mods == ckd_pkg::ModCaps) begin
            if (fingers == '0) begin
               state_in.caps_state = ckd_pkg::step_lock(cur_state.caps_state);
            end else begin
               code = ckd_pkg::CommandTable[fingers];
            end
         end else if (mods == ckd_pkg::ModThumbNum && fingers == '0) begin
            state_in.num_state = ckd_pkg::step_lock(cur_state.num_state);
         end else if (mods == ckd_pkg::ModThumbCaps && fingers == '0) begin
            state_in.caps_state     = ckd_pkg::ShiftOff;
            state_in.num_state      = ckd_pkg::ShiftOff;
            state_in.eshift_pending = 1'b0;
         end else if (mods == ckd_pkg::ModNumCaps) begin
            if (fingers == '0) begin
               state_in.eshift_pending = 1'b1;
            end else begin
               code = ckd_pkg::CounterTable[fingers];
            end
         end else begin
            code = '0;
         end
      end
   end

   assign produce = s1_adv && (code != '0);

   // State memory: one entry, registered read, written back by the decode stage.
   always_ff @(posedge clock) begin
      rd_state_ff <= state_mem[0];
      if (reset) begin
         state_mem[0] <= '0;
      end else if (s1_adv) begin
         state_mem[0] <= state_in;
      end
   end

   // Forwarding of the last write, which the registered read has not seen yet.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b1;
         fwd_state_ff <= '0;
      end else begin
         fwd_valid_ff <= s1_adv;
         if (s1_adv) begin
            fwd_state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_keys_ff <= req.pressed_keys;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_code_ff <= code;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.key_code = rsp_code_ff;

   `CKD_ASSERT(a_rsp_nonzero, rsp_valid_ff |-> (rsp_code_ff != '0), "result code is zero")
   `CKD_ASSERT(a_caps_reachable, s1_valid_ff |-> cur_state.caps_state != 2'd3, "caps state three")
   `CKD_ASSERT(a_num_reachable, s1_valid_ff |-> cur_state.num_state != 2'd3, "num state three")
   `CKD_ASSERT(a_stage_hold, !req.ready |=> s1_valid_ff && $stable(s1_keys_ff), "beat lost")
   `CKD_ASSERT(a_accum_clear, s1_adv |-> (|state_in.chord_accum) == (|s1_keys_ff), "bad clear")

endmodule
